// ===== hw/rtl/mcbpg_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mcbpg_pkg
// Shared types and codes for the multi-channel blink pattern generator.
// ----------------------------------------------------------------------------
package mcbpg_pkg;

    localparam int CNT_W = 16;
    localparam int CH_W  = 2;

    typedef logic [CNT_W-1:0] count_t;
    typedef logic [CH_W-1:0]  chan_t;

    typedef enum logic {
        CMD_TICK = 1'b0,
        CMD_LOAD = 1'b1
    } cmd_t;

endpackage : mcbpg_pkg
`default_nettype wire

// ===== hw/rtl/mcbpg_cmd_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mcbpg_cmd_if
// Command channel: tick or load for one channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface mcbpg_cmd_if;
    import mcbpg_pkg::*;

    logic   valid;
    logic   ready;
    cmd_t   command;
    chan_t  channel;
    count_t off_ticks;
    count_t on_ticks;
    count_t repeat_count;

    modport source (
        output valid, command, channel, off_ticks, on_ticks, repeat_count,
        input  ready
    );

    modport sink (
        input  valid, command, channel, off_ticks, on_ticks, repeat_count,
        output ready
    );
endinterface : mcbpg_cmd_if
`default_nettype wire

// ===== hw/rtl/mcbpg_res_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mcbpg_res_if
// Result channel: drive level and status for each command, valid/ready.
// ----------------------------------------------------------------------------
interface mcbpg_res_if;
    logic valid;
    logic ready;
    logic drive_valid;
    logic drive_level;
    logic finished;
    logic busy_res;

    modport source (
        output valid, drive_valid, drive_level, finished, busy_res,
        input  ready
    );

    modport sink (
        input  valid, drive_valid, drive_level, finished, busy_res,
        output ready
    );
endinterface : mcbpg_res_if
`default_nettype wire

// ===== hw/rtl/multi_channel_blink_pattern_generator_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// multi_channel_blink_pattern_generator_unit
// Per-channel off/on blink sequencer driven by tick and load commands.
// ----------------------------------------------------------------------------
// Usage:
//   cmd carries one command per beat: a load starts a channel with its off
//   time, on time and repeat count (zero counts as one); a tick advances
//   one channel through its off phase, on phase and repeat count.
//   res returns exactly one beat per command: drive_valid/drive_level for
//   a tick on an enabled channel, finished when that tick ended the last
//   period, and busy_res when any of channels 0 to 2 is still running.
//   Commands to channels at or above CHANNELS are ignored.
// Timing:
//   a command lands in the input register on acceptance and its result is
//   registered into the result register once that register is empty or its
//   beat is taken, and the result beat is offered from there. One command
//   per cycle is sustained while res takes every beat: each command reads
//   and rewrites one channel's counters as it leaves the input register.
// Reset:
//   all channels idle, levels off, counters zero, both stages empty.
// Stall:
//   while res is held off, the result register keeps its beat and one more
//   command waits in the input register; cmd.ready then drops.
// ----------------------------------------------------------------------------
module multi_channel_blink_pattern_generator_unit #(
    parameter int CHANNELS = 4
) (
    input  wire          clk,
    input  wire          rst_n,
    mcbpg_cmd_if.sink    cmd,
    mcbpg_res_if.source  res
);
    import mcbpg_pkg::*;

    localparam int BUSY_N = (CHANNELS < 3) ? CHANNELS : 3;

    // per-channel state
    count_t off_rem_reg [CHANNELS];
    count_t on_rem_reg  [CHANNELS];
    count_t off_rl_reg  [CHANNELS];
    count_t on_rl_reg   [CHANNELS];
    count_t per_reg     [CHANNELS];
    logic [CHANNELS-1:0] en_reg;
    logic [CHANNELS-1:0] lvl_reg;

    // input register
    logic   s1_valid_reg;
    cmd_t   s1_cmd_reg;
    chan_t  s1_ch_reg;
    count_t s1_off_reg;
    count_t s1_on_reg;
    count_t s1_rep_reg;

    // result register
    logic out_valid_reg;
    logic drv_valid_reg;
    logic drv_level_reg;
    logic fin_reg;
    logic busy_reg;

    logic advance;
    logic process;
    logic take_in;
    logic [CHANNELS-1:0] hit;

    count_t sel_off_rem, sel_on_rem, sel_off_rl, sel_on_rl, sel_per;
    logic   sel_en, sel_lvl;

    count_t off_rem_next, on_rem_next, off_rl_next, on_rl_next, per_next;
    logic   en_next, lvl_next;
    logic   drv_valid_next, fin_next, busy_next;
    logic [CHANNELS-1:0] en_after;
    count_t per_dec;

    assign advance = !out_valid_reg || res.ready;
    assign process = s1_valid_reg && advance;
    assign cmd.ready = !s1_valid_reg || advance;
    assign take_in = cmd.valid && cmd.ready;

    always_comb
    begin
        for (int k = 0; k < CHANNELS; k++)
        begin
            hit[k] = (int'(s1_ch_reg) == k);
        end
    end

    // read the addressed channel
    always_comb
    begin
        sel_off_rem = '0;
        sel_on_rem  = '0;
        sel_off_rl  = '0;
        sel_on_rl   = '0;
        sel_per     = '0;
        sel_en      = 1'b0;
        sel_lvl     = 1'b0;
        for (int k = 0; k < CHANNELS; k++)
        begin
            if (hit[k])
            begin
                sel_off_rem = off_rem_reg[k];
                sel_on_rem  = on_rem_reg[k];
                sel_off_rl  = off_rl_reg[k];
                sel_on_rl   = on_rl_reg[k];
                sel_per     = per_reg[k];
                sel_en      = en_reg[k];
                sel_lvl     = lvl_reg[k];
            end
        end
    end

    assign per_dec = sel_per - count_t'(1);

    always_comb
    begin
        off_rem_next   = sel_off_rem;
        on_rem_next    = sel_on_rem;
        off_rl_next    = sel_off_rl;
        on_rl_next     = sel_on_rl;
        per_next       = sel_per;
        en_next        = sel_en;
        lvl_next       = sel_lvl;
        drv_valid_next = 1'b0;
        fin_next       = 1'b0;
        if (s1_cmd_reg == CMD_LOAD)
        begin
            en_next      = 1'b1;
            lvl_next     = 1'b0;
            off_rl_next  = s1_off_reg;
            on_rl_next   = s1_on_reg;
            off_rem_next = s1_off_reg;
            on_rem_next  = s1_on_reg;
            per_next     = (s1_rep_reg == '0) ? count_t'(1) : s1_rep_reg;
        end
        else if (sel_en)
        begin
            drv_valid_next = 1'b1;
            if (sel_off_rem == '0)
            begin
                lvl_next = 1'b1;
                if (sel_on_rem == '0)
                begin
                    // end of a period
                    lvl_next = 1'b0;
                    per_next = per_dec;
                    if (per_dec == '0)
                    begin
                        en_next  = 1'b0;
                        fin_next = 1'b1;
                    end
                    else
                    begin
                        if (sel_off_rl != '0)
                        begin
                            off_rem_next = sel_off_rl - count_t'(1);
                        end
                        else
                        begin
                            lvl_next = 1'b1;
                        end
                        on_rem_next = sel_on_rl;
                    end
                end
                else
                begin
                    on_rem_next = sel_on_rem - count_t'(1);
                end
            end
            else
            begin
                off_rem_next = sel_off_rem - count_t'(1);
            end
        end
    end

    always_comb
    begin
        busy_next = 1'b0;
        for (int k = 0; k < CHANNELS; k++)
        begin
            en_after[k] = hit[k] ? en_next : en_reg[k];
        end
        for (int k = 0; k < BUSY_N; k++)
        begin
            busy_next = busy_next | en_after[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            en_reg  <= '0;
            lvl_reg <= '0;
            for (int k = 0; k < CHANNELS; k++)
            begin
                off_rem_reg[k] <= '0;
                on_rem_reg[k]  <= '0;
                off_rl_reg[k]  <= '0;
                on_rl_reg[k]   <= '0;
                per_reg[k]     <= '0;
            end
        end
        else if (process)
        begin
            for (int k = 0; k < CHANNELS; k++)
            begin
                if (hit[k])
                begin
                    off_rem_reg[k] <= off_rem_next;
                    on_rem_reg[k]  <= on_rem_next;
                    off_rl_reg[k]  <= off_rl_next;
                    on_rl_reg[k]   <= on_rl_next;
                    per_reg[k]     <= per_next;
                    en_reg[k]      <= en_next;
                    lvl_reg[k]     <= lvl_next;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.ready)
            begin
                s1_valid_reg <= cmd.valid;
            end
            if (advance)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            s1_cmd_reg <= cmd.command;
            s1_ch_reg  <= cmd.channel;
            s1_off_reg <= cmd.off_ticks;
            s1_on_reg  <= cmd.on_ticks;
            s1_rep_reg <= cmd.repeat_count;
        end
        if (process)
        begin
            // channels that do not exist leave the state untouched and report no drive and no finish
            drv_valid_reg <= (int'(s1_ch_reg) < CHANNELS) && drv_valid_next;
            drv_level_reg <= (int'(s1_ch_reg) < CHANNELS) && drv_valid_next && lvl_next;
            fin_reg       <= (int'(s1_ch_reg) < CHANNELS) && fin_next;
            busy_reg      <= busy_next;
        end
    end

    assign res.valid       = out_valid_reg;
    assign res.drive_valid = drv_valid_reg;
    assign res.drive_level = drv_level_reg;
    assign res.finished    = fin_reg;
    assign res.busy_res    = busy_reg;

    // assertions
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> cmd.ready)
        else $error("command channel stalled with empty result register");

    a_level_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.drive_level |-> res.drive_valid)
        else $error("drive level set without drive valid");

    a_finish_is_off: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.finished |-> res.drive_valid && !res.drive_level)
        else $error("finished beat with level on or no drive valid");

    a_load_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
        process && (s1_cmd_reg == CMD_LOAD) && (int'(s1_ch_reg) < BUSY_N)
        |=> res.valid && res.busy_res)
        else $error("load of a busy-tracked channel did not report busy");

endmodule : multi_channel_blink_pattern_generator_unit
`default_nettype wire

// ===== tb/multi_channel_blink_pattern_generator_unit_tb.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// multi_channel_blink_pattern_generator_unit_tb
// Drives load and tick commands into the blink generator and checks each
// result beat against a cycle-free predictor of the channel counters. Both
// handshakes idle at random; the receiver holds off for long stretches and
// the sender pauses until all results are back at a few points.
// ----------------------------------------------------------------------------
module multi_channel_blink_pattern_generator_unit_tb;
    import mcbpg_pkg::*;

    localparam int NUM_CH = 4;

    localparam chan_t CH_RED       = 2'd0;
    localparam chan_t CH_GREEN     = 2'd1;
    localparam chan_t CH_MOTOR     = 2'd2;
    localparam chan_t CH_BACKLIGHT = 2'd3;

    localparam int TARGET_CMDS = 1200;
    localparam int HOLD_CYCLES = 300;

    typedef struct {
        cmd_t   command;
        chan_t  channel;
        count_t off_ticks;
        count_t on_ticks;
        count_t repeat_count;
        bit     drain_first;    // sender waits until all results are back
    } blink_cmd_t;

    typedef struct {
        logic drive_valid;
        logic drive_level;
        logic finished;
        logic busy_res;
    } blink_res_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    mcbpg_cmd_if cmd_bus ();
    mcbpg_res_if res_bus ();

    multi_channel_blink_pattern_generator_unit #(
        .CHANNELS (NUM_CH)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_bus),
        .res   (res_bus)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // predicted channel state
    count_t off_left  [NUM_CH];
    count_t on_left   [NUM_CH];
    count_t off_init  [NUM_CH];
    count_t on_init   [NUM_CH];
    count_t periods   [NUM_CH];
    bit     ch_on     [NUM_CH];
    bit     lit       [NUM_CH];

    blink_cmd_t cmd_backlog[$];
    blink_res_t expected_drive[$];

    int  fail_count    = 0;
    int  cmds_accepted = 0;
    int  results_seen  = 0;
    int  tx_gap        = 0;
    int  rx_stall      = 0;
    int  hold_left     = 0;
    int  holds_done    = 0;
    bit  drain_next    = 1'b0;
    logic offering;
    blink_res_t rx_want;

    function automatic blink_res_t step_blink(blink_cmd_t c);
        blink_res_t r;
        int ch;
        int k;
        r = '{1'b0, 1'b0, 1'b0, 1'b0};
        ch = c.channel;
        if (ch < NUM_CH)
        begin
            if (c.command == CMD_LOAD)
            begin
                ch_on[ch]    = 1'b1;
                lit[ch]      = 1'b0;
                off_init[ch] = c.off_ticks;
                on_init[ch]  = c.on_ticks;
                off_left[ch] = c.off_ticks;
                on_left[ch]  = c.on_ticks;
                periods[ch]  = (c.repeat_count == '0) ? count_t'(1) : c.repeat_count;
            end
            else if (ch_on[ch])
            begin
                if (off_left[ch] == '0)
                begin
                    lit[ch] = 1'b1;
                    if (on_left[ch] == '0)
                    begin
                        // end of one period
                        lit[ch] = 1'b0;
                        periods[ch] = periods[ch] - 1'b1;
                        if (periods[ch] == '0)
                        begin
                            ch_on[ch]  = 1'b0;
                            r.finished = 1'b1;
                        end
                        else
                        begin
                            // zero off time goes straight back to the on phase
                            if (off_init[ch] != '0)
                                off_left[ch] = off_init[ch] - 1'b1;
                            else
                                lit[ch] = 1'b1;
                            on_left[ch] = on_init[ch];
                        end
                    end
                    else
                        on_left[ch] = on_left[ch] - 1'b1;
                end
                else
                    off_left[ch] = off_left[ch] - 1'b1;
                r.drive_valid = 1'b1;
                r.drive_level = lit[ch];
            end
        end
        // backlight does not count toward busy
        for (k = 0; k < 3 && k < NUM_CH; k++)
            if (ch_on[k])
                r.busy_res = 1'b1;
        return r;
    endfunction

    // mostly short gaps, a few long, and calm stretches with none
    function automatic int idle_len(int beat_no);
        int r;
        if ((beat_no % 400) < 80)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic queue_cmd(cmd_t op, chan_t ch, count_t off_t, count_t on_t, count_t reps);
        blink_cmd_t c;
        c.command      = op;
        c.channel      = ch;
        c.off_ticks    = off_t;
        c.on_ticks     = on_t;
        c.repeat_count = reps;
        c.drain_first  = drain_next;
        drain_next     = 1'b0;
        cmd_backlog.push_back(c);
    endtask

    // payload of a tick is don't-care, so it carries random bits
    task automatic queue_tick(chan_t ch);
        queue_cmd(CMD_TICK, ch, count_t'($urandom), count_t'($urandom), count_t'($urandom));
    endtask

    task automatic queue_ticks(chan_t ch, int n);
        int i;
        for (i = 0; i < n; i++)
            queue_tick(ch);
    endtask

    // sender
    always @(posedge clk)
    begin
        if (!rst_n)
            cmd_bus.valid <= 1'b0;
        else
        begin
            offering = cmd_bus.valid;
            if (cmd_bus.valid && cmd_bus.ready)
            begin
                expected_drive.push_back(step_blink(cmd_backlog.pop_front()));
                cmds_accepted <= cmds_accepted + 1;
                tx_gap = idle_len(cmds_accepted);
                offering = 1'b0;
            end
            if (!offering)
            begin
                if (tx_gap != 0)
                    tx_gap--;
                else if (cmd_backlog.size() != 0 &&
                         (!cmd_backlog[0].drain_first || expected_drive.size() == 0))
                begin
                    cmd_bus.command      <= cmd_backlog[0].command;
                    cmd_bus.channel      <= cmd_backlog[0].channel;
                    cmd_bus.off_ticks    <= cmd_backlog[0].off_ticks;
                    cmd_bus.on_ticks     <= cmd_backlog[0].on_ticks;
                    cmd_bus.repeat_count <= cmd_backlog[0].repeat_count;
                    offering = 1'b1;
                end
            end
            cmd_bus.valid <= offering;
        end
    end

    // long receiver hold-offs so the block backs up into its input
    always @(posedge clk)
    begin
        if (!rst_n)
            hold_left <= 0;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (holds_done < 2 && cmds_accepted >= (holds_done + 1) * 400)
        begin
            hold_left  <= HOLD_CYCLES;
            holds_done <= holds_done + 1;
        end
    end

    task automatic check_bit(string name, logic want, logic got);
        if (got !== want)
        begin
            $error("%s: expected %0b, got %0b", name, want, got);
            fail_count++;
        end
    endtask

    // receiver and checker
    always @(posedge clk)
    begin
        if (!rst_n)
            res_bus.ready <= 1'b0;
        else
        begin
            if (res_bus.valid && res_bus.ready)
            begin
                results_seen++;
                if (expected_drive.size() == 0)
                begin
                    $error("result beat with nothing expected");
                    fail_count++;
                end
                else
                begin
                    rx_want = expected_drive.pop_front();
                    check_bit("drive_valid", rx_want.drive_valid, res_bus.drive_valid);
                    check_bit("drive_level", rx_want.drive_level, res_bus.drive_level);
                    check_bit("finished", rx_want.finished, res_bus.finished);
                    check_bit("busy_res", rx_want.busy_res, res_bus.busy_res);
                end
            end
            if (hold_left != 0)
                res_bus.ready <= 1'b0;
            else if (rx_stall != 0)
            begin
                rx_stall--;
                res_bus.ready <= 1'b0;
            end
            else
            begin
                res_bus.ready <= 1'b1;
                rx_stall = idle_len(results_seen);
            end
        end
    end

    initial
    begin
        int k;
        int n;
        int off_t;
        int on_t;
        int reps;
        int seq_len;
        chan_t ch;

        cmd_bus.valid        = 1'b0;
        cmd_bus.command      = CMD_TICK;
        cmd_bus.channel      = '0;
        cmd_bus.off_ticks    = '0;
        cmd_bus.on_ticks     = '0;
        cmd_bus.repeat_count = '0;
        res_bus.ready        = 1'b0;
        for (k = 0; k < NUM_CH; k++)
        begin
            off_left[k] = '0;
            on_left[k]  = '0;
            off_init[k] = '0;
            on_init[k]  = '0;
            periods[k]  = '0;
            ch_on[k]    = 1'b0;
            lit[k]      = 1'b0;
        end

        // tick on an idle channel right after reset
        queue_tick(CH_RED);
        // zero off, zero on, zero repeats: one period that ends on the first tick
        queue_cmd(CMD_LOAD, CH_RED, 16'h0000, 16'h0000, 16'h0000);
        queue_ticks(CH_RED, 2);
        // two full periods with the off phase reloaded
        queue_cmd(CMD_LOAD, CH_GREEN, 16'h0001, 16'h0001, 16'h0002);
        queue_ticks(CH_GREEN, 7);
        // zero off time skips straight to the on phase between periods
        queue_cmd(CMD_LOAD, CH_MOTOR, 16'h0000, 16'h0002, 16'h0003);
        queue_ticks(CH_MOTOR, 4);
        // restart mid-period with zero on time
        queue_cmd(CMD_LOAD, CH_MOTOR, 16'h0002, 16'h0000, 16'h0001);
        queue_ticks(CH_MOTOR, 4);
        // backlight at the top of every field, not counted in busy
        queue_cmd(CMD_LOAD, CH_BACKLIGHT, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        queue_ticks(CH_BACKLIGHT, 2);

        while (cmd_backlog.size() < TARGET_CMDS)
        begin
            if (cmd_backlog.size() > 600 && cmd_backlog.size() < 620)
                drain_next = 1'b1;
            else if (cmd_backlog.size() < 30)
                drain_next = 1'b1;
            ch = chan_t'($urandom_range(0, NUM_CH - 1));
            if ($urandom_range(0, 99) < 75)
            begin
                // well-formed run: load, then ticks sized to finish it, some sent to random channels
                if ($urandom_range(0, 9) == 0)
                begin
                    off_t = $urandom_range(0, 20);
                    on_t  = $urandom_range(0, 20);
                end
                else
                begin
                    off_t = $urandom_range(0, 3);
                    on_t  = $urandom_range(0, 3);
                end
                reps = $urandom_range(0, 3);
                queue_cmd(CMD_LOAD, ch, count_t'(off_t), count_t'(on_t), count_t'(reps));
                seq_len = (off_t + on_t + 2) * ((reps == 0) ? 1 : reps) + $urandom_range(0, 3);
                for (n = 0; n < seq_len; n++)
                begin
                    if ($urandom_range(0, 3) != 0)
                        queue_tick(ch);
                    else
                        queue_tick(chan_t'($urandom_range(0, NUM_CH - 1)));
                end
            end
            else
            begin
                // noise: full-range loads and stray ticks
                for (n = $urandom_range(1, 4); n > 0; n--)
                begin
                    if ($urandom_range(0, 2) == 0)
                        queue_cmd(CMD_LOAD, chan_t'($urandom_range(0, NUM_CH - 1)),
                                  count_t'($urandom), count_t'($urandom), count_t'($urandom));
                    else
                        queue_tick(chan_t'($urandom_range(0, NUM_CH - 1)));
                end
            end
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (cmd_backlog.size() != 0 || expected_drive.size() != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
        if (fail_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule : multi_channel_blink_pattern_generator_unit_tb
`default_nettype wire

// ===== sim.f =====
hw/rtl/mcbpg_pkg.sv
hw/rtl/mcbpg_cmd_if.sv
hw/rtl/mcbpg_res_if.sv
hw/rtl/multi_channel_blink_pattern_generator_unit.sv
tb/multi_channel_blink_pattern_generator_unit_tb.sv
